FILE: design/sha_pkg.sv
package sha_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_PAD2,
    ST_OUT
  } state_e;

  // Which block of the message is being compressed.
  typedef enum logic [1:0] {
    PH_DATA,
    PH_EXTRA,
    PH_LAST
  } phase_e;

  typedef struct packed {
    logic       wr_byte;
    logic       load;
    logic       round;
    logic       add;
    logic       pad;
    logic       clear;
    logic       len;
    logic       rst_msg;
    logic [5:0] rnd;
    logic [2:0] word_idx;
  } cmd_t;

  typedef struct packed {
    logic [5:0] pos;
  } sts_t;

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LastPos = 6'd63;
  localparam logic [5:0] LastRnd = 6'd63;
  localparam logic [2:0] LastWord = 3'd7;

  function automatic logic [31:0] sha_iv(input logic [2:0] i);
    logic [31:0] r;
    case (i)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] sha_k(input logic [5:0] t);
    logic [31:0] r;
    case (t)
      6'd0:  r = 32'h428a2f98;
      6'd1:  r = 32'h71374491;
      6'd2:  r = 32'hb5c0fbcf;
      6'd3:  r = 32'he9b5dba5;
      6'd4:  r = 32'h3956c25b;
      6'd5:  r = 32'h59f111f1;
      6'd6:  r = 32'h923f82a4;
      6'd7:  r = 32'hab1c5ed5;
      6'd8:  r = 32'hd807aa98;
      6'd9:  r = 32'h12835b01;
      6'd10: r = 32'h243185be;
      6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74;
      6'd13: r = 32'h80deb1fe;
      6'd14: r = 32'h9bdc06a7;
      6'd15: r = 32'hc19bf174;
      6'd16: r = 32'he49b69c1;
      6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6;
      6'd19: r = 32'h240ca1cc;
      6'd20: r = 32'h2de92c6f;
      6'd21: r = 32'h4a7484aa;
      6'd22: r = 32'h5cb0a9dc;
      6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152;
      6'd25: r = 32'ha831c66d;
      6'd26: r = 32'hb00327c8;
      6'd27: r = 32'hbf597fc7;
      6'd28: r = 32'hc6e00bf3;
      6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351;
      6'd31: r = 32'h14292967;
      6'd32: r = 32'h27b70a85;
      6'd33: r = 32'h2e1b2138;
      6'd34: r = 32'h4d2c6dfc;
      6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354;
      6'd37: r = 32'h766a0abb;
      6'd38: r = 32'h81c2c92e;
      6'd39: r = 32'h92722c85;
      6'd40: r = 32'ha2bfe8a1;
      6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70;
      6'd43: r = 32'hc76c51a3;
      6'd44: r = 32'hd192e819;
      6'd45: r = 32'hd6990624;
      6'd46: r = 32'hf40e3585;
      6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116;
      6'd49: r = 32'h1e376c08;
      6'd50: r = 32'h2748774c;
      6'd51: r = 32'h34b0bcb5;
      6'd52: r = 32'h391c0cb3;
      6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f;
      6'd55: r = 32'h682e6ff3;
      6'd56: r = 32'h748f82ee;
      6'd57: r = 32'h78a5636f;
      6'd58: r = 32'h84c87814;
      6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa;
      6'd61: r = 32'ha4506ceb;
      6'd62: r = 32'hbef9a3f7;
      default: r = 32'hc67178f2;
    endcase
    return r;
  endfunction

endpackage

FILE: design/sha_in_if.sv
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       end_of_message;

  modport source (output valid, data_byte, has_byte, end_of_message, input ready);
  modport sink (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

FILE: design/sha_out_if.sv
interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

FILE: design/sha256_byte_stream_hasher_core.sv
// Channel  Dir  Payload                                   Accepted when
// in_i     in   data_byte[8], has_byte, end_of_message    valid && ready
// out_o    out  digest_word[32], word_index[3], last_word valid && ready
//
// Bytes that do not complete a 64-byte block stream at one per cycle. A byte
// that completes a block starts compression: one load, 64 rounds through the
// single round unit, and one chaining add. An end item then costs a padding
// step and a load, the rounds and an add for each padded block
// (two blocks when fewer than nine bytes remain in the last block), then eight
// output items. Reset loads the standard initial hash and clears the byte count.
// Input waits during compression, padding and digest delivery; digest words
// wait for as long as the output's ready stays low.
module sha256_byte_stream_hasher_core (
  input logic        clk_i,
  input logic        rst_ni,
  sha_in_if.sink     in_i,
  sha_out_if.source  out_o
);
  import sha_pkg::*;

  cmd_t        cmd;
  sts_t        sts;
  logic [31:0] digest;

  // The controller sequences byte loading, rounds, padding and digest output.
  sha_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_has_i    (in_i.has_byte),
    .in_end_i    (in_i.end_of_message),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath holds the block buffer, which is also the schedule window,
  // the working words, the chaining words and the message byte count.
  sha_datapath u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .byte_i   (in_i.data_byte),
    .sts_o    (sts),
    .digest_o (digest)
  );

  // Digest words come straight from the chaining registers, which hold still
  // until the last word has been taken.
  assign out_o.digest_word = digest;
  assign out_o.word_index  = cmd.word_idx;
  assign out_o.last_word   = (cmd.word_idx == LastWord);

endmodule

FILE: design/sha_datapath.sv
module sha_datapath (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sha_pkg::cmd_t cmd_i,
  input  logic [7:0]    byte_i,
  output sha_pkg::sts_t sts_o,
  output logic [31:0]   digest_o
);
  import sha_pkg::*;

  logic [31:0] h_q [8];
  logic [31:0] v_q [8];
  logic [31:0] v_d [8];
  logic [31:0] w_q [16];
  logic [31:0] w_d [16];
  logic [60:0] cnt_q;
  logic [63:0] bit_len;
  logic [4:0]  lane_off;
  logic [31:0] w_new;
  logic [31:0] t1;
  logic [31:0] t2;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  assign bit_len  = {cnt_q, 3'b000};
  // Bytes are packed big-endian: byte 0 of a word sits in bits 31:24.
  assign lane_off = {~cnt_q[1:0], 3'b000};

  assign w_new = w_q[0]
               + (rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3))
               + w_q[9]
               + (rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10));

  assign t1 = v_q[7]
            + (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25))
            + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
            + sha_k(cmd_i.rnd)
            + w_q[0];
  assign t2 = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22))
            + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

  // The block buffer doubles as the 16-word schedule window.
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      w_d[i] = w_q[i];
    end
    if (cmd_i.round) begin
      for (int i = 0; i < 15; i++) begin
        w_d[i] = w_q[i+1];
      end
      w_d[15] = w_new;
    end else begin
      if (cmd_i.wr_byte) begin
        w_d[cnt_q[5:2]][lane_off +: 8] = byte_i;
      end
      if (cmd_i.pad) begin
        for (int i = 0; i < 16; i++) begin
          for (int b = 0; b < 4; b++) begin
            if (6'(4 * i + b) == cnt_q[5:0]) begin
              w_d[i][8*(3-b) +: 8] = PadByte;
            end else if (6'(4 * i + b) > cnt_q[5:0]) begin
              w_d[i][8*(3-b) +: 8] = 8'h00;
            end
          end
        end
      end
      if (cmd_i.clear) begin
        for (int i = 0; i < 16; i++) begin
          w_d[i] = 32'h0;
        end
      end
      if (cmd_i.len) begin
        w_d[14] = bit_len[63:32];
        w_d[15] = bit_len[31:0];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      v_d[i] = v_q[i];
    end
    if (cmd_i.load) begin
      for (int i = 0; i < 8; i++) begin
        v_d[i] = h_q[i];
      end
    end else if (cmd_i.round) begin
      v_d[7] = v_q[6];
      v_d[6] = v_q[5];
      v_d[5] = v_q[4];
      v_d[4] = v_q[3] + t1;
      v_d[3] = v_q[2];
      v_d[2] = v_q[1];
      v_d[1] = v_q[0];
      v_d[0] = t1 + t2;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 16; i++) begin
      w_q[i] <= w_d[i];
    end
    for (int i = 0; i < 8; i++) begin
      v_q[i] <= v_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      for (int i = 0; i < 8; i++) begin
        h_q[i] <= sha_iv(3'(i));
      end
    end else begin
      if (cmd_i.rst_msg) begin
        cnt_q <= '0;
        for (int i = 0; i < 8; i++) begin
          h_q[i] <= sha_iv(3'(i));
        end
      end else begin
        if (cmd_i.wr_byte) begin
          cnt_q <= cnt_q + 61'd1;
        end
        if (cmd_i.add) begin
          for (int i = 0; i < 8; i++) begin
            h_q[i] <= h_q[i] + v_q[i];
          end
        end
      end
    end
  end

  assign sts_o.pos = cnt_q[5:0];
  assign digest_o  = h_q[cmd_i.word_idx];

endmodule

FILE: design/sha_ctrl.sv
module sha_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_has_i,
  input  logic          in_end_i,
  output logic          in_ready_o,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  input  sha_pkg::sts_t sts_i,
  output sha_pkg::cmd_t cmd_o
);
  import sha_pkg::*;

  state_e     state_q, state_d;
  phase_e     phase_q;
  logic [5:0] rnd_q;
  logic [2:0] idx_q;
  logic       end_q;
  logic       in_acc;
  logic       out_acc;
  logic       no_room;

  assign in_acc  = (state_q == ST_IDLE) && in_valid_i;
  assign out_acc = (state_q == ST_OUT) && out_ready_i;
  // From byte 56 on the length field no longer fits in the block.
  assign no_room = sts_i.pos inside {[6'd56:6'd63]};

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_has_i && (sts_i.pos == LastPos)) begin
            state_d = ST_LOAD;
          end else if (in_end_i) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_LOAD:  state_d = ST_ROUND;
      ST_ROUND: begin
        if (rnd_q == LastRnd) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        case (phase_q)
          PH_DATA:  state_d = end_q ? ST_PAD : ST_IDLE;
          PH_EXTRA: state_d = ST_PAD2;
          PH_LAST:  state_d = ST_OUT;
          default:  state_d = ST_IDLE;
        endcase
      end
      ST_PAD:  state_d = ST_LOAD;
      ST_PAD2: state_d = ST_LOAD;
      ST_OUT: begin
        if (out_ready_i && (idx_q == LastWord)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.rnd      = rnd_q;
    cmd_o.word_idx = idx_q;
    in_ready_o     = 1'b0;
    out_valid_o    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.wr_byte = in_valid_i && in_has_i;
      end
      ST_LOAD:  cmd_o.load = 1'b1;
      ST_ROUND: cmd_o.round = 1'b1;
      ST_ADD:   cmd_o.add = 1'b1;
      ST_PAD: begin
        cmd_o.pad = 1'b1;
        cmd_o.len = !no_room;
      end
      ST_PAD2: begin
        cmd_o.clear = 1'b1;
        cmd_o.len   = 1'b1;
      end
      ST_OUT: begin
        out_valid_o   = 1'b1;
        cmd_o.rst_msg = out_ready_i && (idx_q == LastWord);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_DATA;
      rnd_q   <= '0;
      idx_q   <= '0;
      end_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        end_q   <= in_end_i;
        phase_q <= PH_DATA;
      end
      if (state_q == ST_PAD) begin
        phase_q <= no_room ? PH_EXTRA : PH_LAST;
      end
      if (state_q == ST_PAD2) begin
        phase_q <= PH_LAST;
      end
      if (state_q == ST_LOAD) begin
        rnd_q <= '0;
      end else if (state_q == ST_ROUND) begin
        rnd_q <= rnd_q + 6'd1;
      end
      if (out_acc) begin
        idx_q <= idx_q + 3'd1;
      end
    end
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input and digest output open at once");

  a_round_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == ST_ROUND) |-> $past(state_q == ST_LOAD))
    else $error("rounds started without loading working words");

  a_rounds_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND && rnd_q == LastRnd) |=> (state_q == ST_ADD))
    else $error("compression did not end after 64 rounds");

  a_digest_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && idx_q == LastWord) |=> (state_q == ST_IDLE && idx_q == 3'd0))
    else $error("digest delivery did not return to idle");

endmodule
